// File: rtl/core/lqbm_pkg.sv
package lqbm_pkg;

  // payload field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned NodeW  = 4;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned FreeOutW = 5;

  // pool size default, number of nodes on the free list after reset
  localparam int unsigned DefaultCapacity = 15;

  // free counter saturates at the top of this width
  localparam int unsigned CountW = 16;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// File: rtl/core/lqbm_if.sv
// command channel
interface lqbm_cmd_if import lqbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [NodeW-1:0] node;

  modport source (output valid, output cmd, output node, input ready);
  modport sink   (input valid, input cmd, input node, output ready);
endinterface

// response channel
interface lqbm_rsp_if import lqbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [SlotW-1:0]    slot;
  logic [SlotW-1:0]    release_node;
  logic [FreeOutW-1:0] free_count;

  modport source (output valid, output ok, output slot, output release_node,
                  output free_count, input ready);
  modport sink   (input valid, input ok, input slot, input release_node,
                  input free_count, output ready);
endinterface

// File: rtl/core/linked_queue_buffer_manager_unit.sv
// Node pool manager: CAPACITY+1 node slots kept as a free-list stack and a
// singly linked FIFO that always holds one dummy node at its head. Commands
// are allocate, append, dequeue and free; each returns one response with the
// free count after the command. The accept cycle issues reads of both link
// memories, and the next cycle applies the update and loads the response
// register. A new command is taken only once the current one has been
// applied and the response register is free or being read. The link
// memories have a registered read. After reset a clearing pass writes
// every entry of both link memories; no command is accepted until it ends.
// Node indices from the caller are not checked against the list contents.
module linked_queue_buffer_manager_unit import lqbm_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lqbm_cmd_if.sink    req_i,
  lqbm_rsp_if.source  rsp_o
);

  localparam int unsigned PoolNodes = CAPACITY + 1;
  localparam int unsigned IdxW      = $clog2(PoolNodes);
  localparam int unsigned LinkW     = $clog2(PoolNodes + 1);
  localparam logic [LinkW-1:0]  LinkInvalid = LinkW'(PoolNodes);
  localparam logic [IdxW-1:0]   LastIdx     = IdxW'(PoolNodes - 1);
  localparam logic [CountW-1:0] CountMax    = '1;

  // link memories
  logic [LinkW-1:0] free_mem  [PoolNodes];
  logic [LinkW-1:0] queue_mem [PoolNodes];

  // control and pointer registers
  state_e            state_q, state_d;
  logic [IdxW-1:0]   init_idx_q, init_idx_d;
  logic [LinkW-1:0]  free_top_q, free_top_d;
  logic [CountW-1:0] free_size_q, free_size_d;
  logic [IdxW-1:0]   front_q, front_d;
  logic [IdxW-1:0]   back_q, back_d;
  cmd_e              cmd_q, cmd_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic              out_valid_q, out_valid_d;

  // response payload registers
  logic                ok_q, ok_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [SlotW-1:0]    rel_q, rel_d;
  logic [FreeOutW-1:0] count_q, count_d;

  // memory read and write controls
  logic             rd_en;
  logic [IdxW-1:0]  free_rd_addr;
  logic [LinkW-1:0] free_rd_q;
  logic [LinkW-1:0] queue_rd_q;
  logic             free_we;
  logic [IdxW-1:0]  free_wr_addr;
  logic [LinkW-1:0] free_wr_data;
  logic             queue_we;
  logic [IdxW-1:0]  queue_wr_addr;
  logic [LinkW-1:0] queue_wr_data;

  // decoded conditions
  logic             accept;
  logic             top_ok;
  logic             node_ok;
  logic             next_ok;
  logic [IdxW-1:0]  node_idx;
  logic [IdxW-1:0]  top_idx;

  assign top_ok   = (free_top_q < LinkInvalid);
  assign node_ok  = (32'(node_q) < 32'(PoolNodes));
  assign next_ok  = (queue_rd_q < LinkInvalid);
  assign node_idx = IdxW'(node_q);
  assign top_idx  = free_top_q[IdxW-1:0];

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.ok           = ok_q;
  assign rsp_o.slot         = slot_q;
  assign rsp_o.release_node = rel_q;
  assign rsp_o.free_count   = count_q;

  // an invalid top addresses entry zero, its data goes unused
  assign rd_en        = accept;
  assign free_rd_addr = top_ok ? top_idx : '0;

  // next state, list updates and response
  always_comb begin
    state_d       = state_q;
    init_idx_d    = init_idx_q;
    free_top_d    = free_top_q;
    free_size_d   = free_size_q;
    front_d       = front_q;
    back_d        = back_q;
    cmd_d         = cmd_q;
    node_d        = node_q;
    out_valid_d   = out_valid_q;
    ok_d          = ok_q;
    slot_d        = slot_q;
    rel_d         = rel_q;
    count_d       = count_q;
    free_we       = 1'b0;
    free_wr_addr  = init_idx_q;
    free_wr_data  = LinkW'(init_idx_q) + LinkW'(1);
    queue_we      = 1'b0;
    queue_wr_addr = init_idx_q;
    queue_wr_data = LinkInvalid;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        // clearing pass: free entry i links to i+1, queue links invalid
        free_we  = 1'b1;
        queue_we = 1'b1;
        if (init_idx_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          init_idx_d = init_idx_q + IdxW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_e'(req_i.cmd);
          node_d  = req_i.node;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ok_d    = 1'b1;
        slot_d  = '0;
        rel_d   = '0;
        state_d = ST_IDLE;
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (!top_ok) begin
              ok_d = 1'b0;
            end else begin
              free_top_d = free_rd_q;
              if (free_size_q != '0) begin
                free_size_d = free_size_q - CountW'(1);
              end
              queue_we      = 1'b1;
              queue_wr_addr = top_idx;
              queue_wr_data = LinkInvalid;
              slot_d        = SlotW'(free_top_q);
            end
          end
          CMD_APPEND: begin
            if (node_ok) begin
              queue_we      = 1'b1;
              queue_wr_addr = back_q;
              queue_wr_data = LinkW'(node_q);
              back_d        = node_idx;
            end
          end
          CMD_DEQUEUE: begin
            if (!next_ok) begin
              ok_d = 1'b0;
            end else begin
              front_d = queue_rd_q[IdxW-1:0];
              slot_d  = SlotW'(queue_rd_q);
              rel_d   = SlotW'(front_q);
            end
          end
          CMD_FREE: begin
            if (node_ok) begin
              free_we      = 1'b1;
              free_wr_addr = node_idx;
              free_wr_data = free_top_q;
              free_top_d   = LinkW'(node_q);
              if (free_size_q != CountMax) begin
                free_size_d = free_size_q + CountW'(1);
              end
            end
          end
          default: begin
            ok_d = 1'b1;
          end
        endcase
        count_d     = free_size_d[FreeOutW-1:0];
        out_valid_d = 1'b1;
      end

      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_idx_q  <= '0;
      free_top_q  <= LinkW'(1);
      free_size_q <= CountW'(CAPACITY);
      front_q     <= '0;
      back_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      free_top_q  <= free_top_d;
      free_size_q <= free_size_d;
      front_q     <= front_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command and response payload
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    node_q  <= node_d;
    ok_q    <= ok_d;
    slot_q  <= slot_d;
    rel_q   <= rel_d;
    count_q <= count_d;
  end

  // free link memory
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_wr_addr] <= free_wr_data;
    end
    if (rd_en) begin
      free_rd_q <= free_mem[free_rd_addr];
    end
  end

  // queue link memory
  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_wr_addr] <= queue_wr_data;
    end
    if (rd_en) begin
      queue_rd_q <= queue_mem[front_q];
    end
  end

endmodule
